// File: rtl/core/alr_pkg.sv
package alr_pkg;

    localparam int COORD_BITS  = 10;
    localparam int FRAC_BITS   = 16;
    localparam int COLOR_BITS  = 16;
    localparam int COMP_BITS   = 5;
    localparam int ACC_BITS    = COORD_BITS + FRAC_BITS + 1;
    localparam int SLOPE_BITS  = FRAC_BITS + 2;
    localparam int DIV_BITS    = COORD_BITS + FRAC_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_BITS + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

    // Colour layout: red at 15..11, green at 10..6, blue at 4..0.
    localparam int R_LSB = 11;
    localparam int G_LSB = 6;
    localparam int B_LSB = 0;
    localparam logic [COMP_BITS-1:0] COMP_MAX = '1;

    typedef enum logic {
        OP_START   = 1'b0,
        OP_ADVANCE = 1'b1
    } t_op;

    typedef logic [COORD_BITS-1:0] t_coord;

    // One command passed from the front end to the pixel engine.
    typedef struct packed {
        t_op                   op;
        logic                  steep;
        logic                  zero_len;
        logic                  has_interior;
        t_coord                a0;
        t_coord                b0;
        t_coord                a1;
        t_coord                b1;
        logic [SLOPE_BITS-1:0] slope;
        logic [COLOR_BITS-1:0] color;
        logic                  bright;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// File: rtl/core/alr_if.sv
interface alr_line_if import alr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  operation;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
    logic [COLOR_BITS-1:0] line_color;
    logic                  bright_mode;

    modport source (
        output valid, operation, start_x, start_y, end_x, end_y, line_color, bright_mode,
        input  ready
    );
    modport sink (
        input  valid, operation, start_x, start_y, end_x, end_y, line_color, bright_mode,
        output ready
    );
endinterface

interface alr_pixel_if import alr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  only_if_differs;
    logic [COLOR_BITS-1:0] compare_color;
    logic                  line_done;

    modport source (
        output valid, pixel_x, pixel_y, pixel_color, only_if_differs, compare_color,
               line_done,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, pixel_color, only_if_differs, compare_color,
               line_done,
        output ready
    );
endinterface

// File: rtl/core/alr_front.sv
module alr_front import alr_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    alr_line_if.sink        i_line,
    input  t_q_stat         i_q_stat,
    output logic            o_push_valid,
    output t_cmd            o_push_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_PUSH
    } t_state;

    t_state                  r_state;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic [COORD_BITS-1:0]   r_rem;
    logic [DIV_BITS-1:0]     r_dq;
    logic [COORD_BITS-1:0]   r_span;
    logic                    r_neg;
    t_cmd                    r_cmd;

    logic                    in_ready;
    logic                    accept;
    logic                    adv_push;

    // Orientation of a new line, worked out from the request fields.
    logic [COORD_BITS-1:0]   adx, ady, a0, b0, a1, b1, span, dmag;
    logic                    steep, neg, zero_len;

    // One restoring division step.
    logic [COORD_BITS:0]     trial;
    logic                    qbit;
    logic [COORD_BITS-1:0]   n_rem;

    logic [SLOPE_BITS-1:0]   quo;
    logic [SLOPE_BITS-1:0]   slope;

    always_comb begin
        adx = (i_line.start_x > i_line.end_x) ? i_line.start_x - i_line.end_x
                                              : i_line.end_x - i_line.start_x;
        ady = (i_line.start_y > i_line.end_y) ? i_line.start_y - i_line.end_y
                                              : i_line.end_y - i_line.start_y;
        steep    = !(adx > ady);
        zero_len = (adx == '0) && (ady == '0);
        if (!steep) begin
            a0 = i_line.start_x; b0 = i_line.start_y;
            a1 = i_line.end_x;   b1 = i_line.end_y;
        end else begin
            a0 = i_line.start_y; b0 = i_line.start_x;
            a1 = i_line.end_y;   b1 = i_line.end_x;
        end
        if (a1 < a0) begin
            {a0, a1} = {a1, a0};
            {b0, b1} = {b1, b0};
        end
        span = a1 - a0;
        neg  = b1 < b0;
        dmag = neg ? b0 - b1 : b1 - b0;
    end

    always_comb begin
        trial = {r_rem, r_dq[DIV_BITS-1]};
        qbit  = trial >= {1'b0, r_span};
        n_rem = qbit ? COORD_BITS'(trial - {1'b0, r_span}) : trial[COORD_BITS-1:0];
    end

    // The quotient never exceeds one in fixed point, so the low bits hold it.
    assign quo   = r_dq[SLOPE_BITS-1:0];
    assign slope = r_neg ? SLOPE_BITS'(0) - quo : quo;

    assign in_ready     = (r_state == S_IDLE) && !i_q_stat.full;
    assign i_line.ready = in_ready;
    assign accept       = i_line.valid && in_ready;
    assign adv_push     = accept && (i_line.operation == OP_ADVANCE);

    always_comb begin
        o_push_valid = 1'b0;
        o_push_cmd   = r_cmd;
        o_push_cmd.slope        = slope;
        o_push_cmd.has_interior = r_span >= COORD_BITS'(2);
        if (adv_push) begin
            o_push_valid = 1'b1;
            o_push_cmd   = '0;
            o_push_cmd.op = OP_ADVANCE;
        end else if (r_state == S_PUSH && !i_q_stat.full) begin
            o_push_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept && i_line.operation == OP_START) begin
                        r_cmd.op       <= OP_START;
                        r_cmd.steep    <= steep;
                        r_cmd.zero_len <= zero_len;
                        r_cmd.has_interior <= 1'b0;
                        r_cmd.a0       <= a0;
                        r_cmd.b0       <= b0;
                        r_cmd.a1       <= a1;
                        r_cmd.b1       <= b1;
                        r_cmd.slope    <= '0;
                        r_cmd.color    <= i_line.line_color;
                        r_cmd.bright   <= i_line.bright_mode;
                        r_span         <= span;
                        r_neg          <= neg;
                        r_rem          <= '0;
                        r_dq           <= {dmag, {FRAC_BITS{1'b0}}};
                        r_cnt          <= DIV_CNT_BITS'(DIV_BITS);
                        r_state        <= zero_len ? S_PUSH : S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= n_rem;
                    r_dq  <= {r_dq[DIV_BITS-2:0], qbit};
                    r_cnt <= r_cnt - DIV_CNT_BITS'(1);
                    if (r_cnt == DIV_CNT_BITS'(1)) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (!i_q_stat.full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/core/alr_queue.sv
module alr_queue import alr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push_valid,
    input  t_cmd    i_push_cmd,
    input  logic    i_pop,
    output t_cmd    o_head,
    output t_q_stat o_stat
);

    t_cmd                    r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] r_wr;
    logic [QUEUE_PTR_BITS-1:0] r_rd;
    logic [QUEUE_PTR_BITS:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_stat.full  = r_count == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH);
    assign o_stat.empty = r_count == '0;
    assign o_head       = r_mem[r_rd];
    assign do_push      = i_push_valid && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + QUEUE_PTR_BITS'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QUEUE_PTR_BITS'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (QUEUE_PTR_BITS+1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (QUEUE_PTR_BITS+1)'(1);
            end
        end
    end

endmodule

// File: rtl/core/alr_back.sv
module alr_back import alr_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cmd         i_head,
    input  t_q_stat      i_q_stat,
    output logic         o_pop,
    alr_pixel_if.source  o_pixel
);

    typedef struct packed {
        t_coord                x;
        t_coord                y;
        logic [COLOR_BITS-1:0] color;
        logic                  only_if_differs;
        logic [COLOR_BITS-1:0] compare_color;
        logic                  line_done;
    } t_pix;

    localparam logic [FRAC_BITS:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // Scales each component by the coverage, or in bright mode adds a
    // whitening term that grows as coverage falls and saturates.
    function automatic logic [COLOR_BITS-1:0] blend(
        input logic [COLOR_BITS-1:0] color,
        input logic                  bright,
        input logic [FRAC_BITS:0]    cov
    );
        logic [COMP_BITS-1:0]   comp [3];
        logic [FRAC_BITS+5:0]   prod;
        logic [FRAC_BITS+5:0]   white;
        logic [COMP_BITS:0]     sum;
        logic [COLOR_BITS-1:0]  res;
        comp[0] = color[R_LSB +: COMP_BITS];
        comp[1] = color[G_LSB +: COMP_BITS];
        comp[2] = color[B_LSB +: COMP_BITS];
        white = (FRAC_BITS+6)'(COMP_MAX) * (FRAC_BITS+6)'(FRAC_ONE - cov);
        for (int k = 0; k < 3; k++) begin
            if (bright) begin
                sum = {1'b0, comp[k]} + {1'b0, white[FRAC_BITS +: COMP_BITS]};
                comp[k] = sum[COMP_BITS] ? COMP_MAX : sum[COMP_BITS-1:0];
            end else begin
                prod = (FRAC_BITS+6)'(comp[k]) * (FRAC_BITS+6)'(cov);
                comp[k] = prod[FRAC_BITS +: COMP_BITS];
            end
        end
        res = '0;
        res[R_LSB +: COMP_BITS] = comp[0];
        res[G_LSB +: COMP_BITS] = comp[1];
        res[B_LSB +: COMP_BITS] = comp[2];
        return res;
    endfunction

    logic                  r_active;
    logic                  r_phase;
    logic                  r_steep;
    t_coord                r_pos;
    t_coord                r_end;
    logic [ACC_BITS-1:0]   r_acc;
    logic [SLOPE_BITS-1:0] r_slope;
    logic [COLOR_BITS-1:0] r_color;
    logic                  r_bright;
    logic                  r_out_valid;
    t_pix                  r_out;

    logic                  n_active, n_phase, n_steep, n_bright;
    t_coord                n_pos, n_end;
    logic [ACC_BITS-1:0]   n_acc;
    logic [SLOPE_BITS-1:0] n_slope;
    logic [COLOR_BITS-1:0] n_color;

    logic                  can_emit;
    logic                  emit;
    t_pix                  pix;

    logic [FRAC_BITS-1:0]  frac;
    t_coord                base;
    t_coord                minor;
    logic                  last_col;
    logic [FRAC_BITS:0]    cov;
    logic [COLOR_BITS-1:0] blended;
    logic [ACC_BITS-1:0]   head_acc;

    assign can_emit = !r_out_valid || o_pixel.ready;

    assign frac     = r_acc[FRAC_BITS-1:0];
    assign base     = r_acc[FRAC_BITS +: COORD_BITS];
    assign last_col = ({1'b0, r_pos} + (COORD_BITS+1)'(1)) >= {1'b0, r_end};
    assign cov      = r_phase ? {1'b0, frac} : FRAC_ONE - {1'b0, frac};
    assign blended  = blend(r_color, r_bright, cov);
    assign minor    = r_phase ? base + COORD_BITS'(1) : base;
    assign head_acc = {1'b0, i_head.b0, {FRAC_BITS{1'b0}}}
                    + {{(ACC_BITS-SLOPE_BITS){i_head.slope[SLOPE_BITS-1]}}, i_head.slope};

    always_comb begin
        n_active = r_active;
        n_phase  = r_phase;
        n_steep  = r_steep;
        n_bright = r_bright;
        n_pos    = r_pos;
        n_end    = r_end;
        n_acc    = r_acc;
        n_slope  = r_slope;
        n_color  = r_color;
        o_pop    = 1'b0;
        emit     = 1'b0;
        pix      = '0;
        if (!i_q_stat.empty && can_emit) begin
            unique case (i_head.op)
                OP_START: begin
                    emit = 1'b1;
                    pix.color         = i_head.color;
                    pix.compare_color = i_head.color;
                    if (!r_phase) begin
                        // First endpoint; the line state is taken on here.
                        pix.x = i_head.steep ? i_head.b0 : i_head.a0;
                        pix.y = i_head.steep ? i_head.a0 : i_head.b0;
                        pix.line_done = i_head.zero_len;
                        n_steep  = i_head.steep;
                        n_color  = i_head.color;
                        n_bright = i_head.bright;
                        n_active = i_head.has_interior;
                        n_pos    = i_head.a0 + COORD_BITS'(1);
                        n_end    = i_head.a1;
                        n_slope  = i_head.slope;
                        n_acc    = head_acc;
                        if (i_head.zero_len) begin
                            o_pop = 1'b1;
                        end else begin
                            n_phase = 1'b1;
                        end
                    end else begin
                        pix.x = i_head.steep ? i_head.b1 : i_head.a1;
                        pix.y = i_head.steep ? i_head.a1 : i_head.b1;
                        pix.line_done = !i_head.has_interior;
                        o_pop   = 1'b1;
                        n_phase = 1'b0;
                    end
                end
                OP_ADVANCE: begin
                    if (!r_active) begin
                        o_pop = 1'b1;
                    end else begin
                        emit = 1'b1;
                        pix.x = r_steep ? minor : r_pos;
                        pix.y = r_steep ? r_pos : minor;
                        pix.compare_color = r_color;
                        if (frac == '0) begin
                            pix.color     = r_color;
                            pix.line_done = last_col;
                        end else begin
                            pix.color           = blended;
                            pix.only_if_differs = 1'b1;
                            pix.line_done       = r_phase && last_col;
                        end
                        if (frac == '0 || r_phase) begin
                            // Column finished: step along the line.
                            o_pop   = 1'b1;
                            n_phase = 1'b0;
                            n_acc   = r_acc
                                    + {{(ACC_BITS-SLOPE_BITS){r_slope[SLOPE_BITS-1]}}, r_slope};
                            n_pos   = r_pos + COORD_BITS'(1);
                            if (last_col) begin
                                n_active = 1'b0;
                            end
                        end else begin
                            n_phase = 1'b1;
                        end
                    end
                end
                default: begin
                    o_pop = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_active <= n_active;
            r_phase  <= n_phase;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_pixel.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_steep  <= n_steep;
        r_bright <= n_bright;
        r_pos    <= n_pos;
        r_end    <= n_end;
        r_acc    <= n_acc;
        r_slope  <= n_slope;
        r_color  <= n_color;
        if (emit) begin
            r_out <= pix;
        end
    end

    assign o_pixel.valid           = r_out_valid;
    assign o_pixel.pixel_x         = r_out.x;
    assign o_pixel.pixel_y         = r_out.y;
    assign o_pixel.pixel_color     = r_out.color;
    assign o_pixel.only_if_differs = r_out.only_if_differs;
    assign o_pixel.compare_color   = r_out.compare_color;
    assign o_pixel.line_done       = r_out.line_done;

endmodule

// File: rtl/core/antialiased_line_rasterizer.sv
// Throughput: the front end takes an advance request whenever it is idle and the queue has
// room, and the pixel engine sends one pixel per cycle while the consumer does not stall
// it, so an advance whose line falls between two pixel centres sends two pixels; a start
// request holds the input while the bit-serial gradient divider runs and until its command
// enters the queue, and a zero-length line skips the divider. Reset is synchronous and
// active low; it empties the queue, drops the output and ends any line.
module antialiased_line_rasterizer import alr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    alr_line_if.sink    i_line,
    alr_pixel_if.source o_pixel
);

    // The front end takes each request, orders the endpoints of a new line
    // along its major axis and divides out the gradient. Commands then wait
    // in a short queue, so that advance requests keep flowing in while the
    // pixel engine is held up by a slow consumer.
    logic    push_valid;
    t_cmd    push_cmd;
    logic    pop;
    t_cmd    head;
    t_q_stat q_stat;

    alr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_line       (i_line),
        .i_q_stat     (q_stat),
        .o_push_valid (push_valid),
        .o_push_cmd   (push_cmd)
    );

    alr_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_cmd   (push_cmd),
        .i_pop        (pop),
        .o_head       (head),
        .o_stat       (q_stat)
    );

    // The pixel engine holds the line being drawn: the next major column,
    // the minor position in fixed point and the colour. It sends both
    // endpoints of a new line at full colour (one pixel for a zero-length
    // line), then for each advance request one pixel when the line falls
    // exactly on a pixel centre, otherwise two blended pixels that the
    // consumer writes only where they differ from the line colour. Its
    // output register holds a pixel steady while the consumer stalls.
    alr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_pixel  (o_pixel)
    );

endmodule

// File: rtl/core/alr_checker.sv
module alr_checker import alr_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_line_valid,
    input logic                  i_line_ready,
    input logic                  i_line_operation,
    input logic                  i_pix_valid,
    input logic                  i_pix_ready,
    input logic [COLOR_BITS-1:0] i_pix_color,
    input logic                  i_pix_cond,
    input logic [COLOR_BITS-1:0] i_pix_compare
);

    // An accepted start request always leaves the front end busy in the next cycle.
    a_start_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_line_valid && i_line_ready && (i_line_operation == OP_START) |=> !i_line_ready)
        else $error("input ready straight after a start request");

    // Unconditional pixels are always drawn in the line colour itself.
    a_full_colour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix_valid && !i_pix_cond |-> i_pix_color == i_pix_compare)
        else $error("unconditional pixel not in line colour");

    a_pix_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix_valid && !i_pix_ready |=> i_pix_valid)
        else $error("pixel request withdrawn while stalled");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_pix_valid)
        else $error("pixel request valid after reset");

endmodule

bind antialiased_line_rasterizer alr_checker u_alr_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_line_valid     (i_line.valid),
    .i_line_ready     (i_line.ready),
    .i_line_operation (i_line.operation),
    .i_pix_valid      (o_pixel.valid),
    .i_pix_ready      (o_pixel.ready),
    .i_pix_color      (o_pixel.pixel_color),
    .i_pix_cond       (o_pixel.only_if_differs),
    .i_pix_compare    (o_pixel.compare_color)
);

// File: tb/sv/antialiased_line_rasterizer_tb.sv
`timescale 1ns / 100ps

module antialiased_line_rasterizer_tb;
    import alr_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_ITEMS = 950;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_LINE    = 12;
    localparam int DRAIN_LINE   = 40;
    localparam int TAIL_CYCLES  = 64;
    localparam int TIMEOUT_NS   = 8_000_000;
    localparam int MAX_PRINTED  = 40;
    localparam int N_DIRECTED   = 24;

    // One request on the line channel, at the widths of the block.
    typedef struct packed {
        t_op                   op;
        t_coord                x1;
        t_coord                y1;
        t_coord                x2;
        t_coord                y2;
        logic [COLOR_BITS-1:0] colour;
        logic                  bright;
    } t_req;

    // One pixel on the output channel.
    typedef struct packed {
        t_coord                x;
        t_coord                y;
        logic [COLOR_BITS-1:0] colour;
        logic                  cond;
        logic [COLOR_BITS-1:0] cmp;
        logic                  done;
    } t_px;

    // A row of the directed table. Where typed is set, the pixels written in
    // the row are what the block must produce; otherwise the predictor decides.
    typedef struct packed {
        t_req       req;
        logic       typed;
        logic [1:0] n_typed;
        t_px        p0;
        t_px        p1;
    } t_row;

    // Receiver behaviour between long hold-offs.
    typedef enum logic [1:0] {
        RX_FREE,
        RX_COIN,
        RX_SPARSE,
        RX_RHYTHM
    } t_rx_mode;

    logic clk = 1'b0;
    logic rst_n;

    alr_line_if  line_if ();
    alr_pixel_if pix_if ();

    antialiased_line_rasterizer i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_line  (line_if),
        .o_pixel (pix_if)
    );

    always begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Predictor state: a line in progress, its axis, the next interior column,
    // the last major coordinate, the unsigned minor position in fixed point, the
    // two's complement gradient, and the colour and mode latched at the start.
    logic                  ln_active   = 1'b0;
    logic                  ln_steep    = 1'b0;
    t_coord                ln_major    = '0;
    t_coord                ln_major_end = '0;
    logic [ACC_BITS-1:0]   ln_accum    = '0;
    logic [SLOPE_BITS-1:0] ln_slope    = '0;
    logic [COLOR_BITS-1:0] ln_colour   = '0;
    logic                  ln_bright   = 1'b0;

    t_px pending_pixels [$];
    int  mismatches  = 0;
    int  pixels_seen = 0;
    int  burst_left  = 0;
    logic hold_req = 1'b0;
    logic hold_on  = 1'b0;

    // Directed rows. Typed rows cover what can be read off directly: advances
    // with no line in progress, zero-length lines, full-colour endpoints at the
    // corners of the coordinate range and a line too short to have an interior.
    t_row directed_rows [N_DIRECTED] = '{
        // Advance straight after reset: nothing comes out.
        '{'{OP_ADVANCE, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 16'hFFFF, 1'b1},
          1'b1, 2'd0, '0, '0},
        // Zero-length lines at both corners give a single finished pixel.
        '{'{OP_START, 10'd0, 10'd0, 10'd0, 10'd0, 16'hFFFF, 1'b0}, 1'b1, 2'd1,
          '{10'd0, 10'd0, 16'hFFFF, 1'b0, 16'hFFFF, 1'b1}, '0},
        '{'{OP_START, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 16'h0000, 1'b1},
          1'b1, 2'd1, '{10'd1023, 10'd1023, 16'h0000, 1'b0, 16'h0000, 1'b1}, '0},
        '{'{OP_ADVANCE, 10'd0, 10'd0, 10'd0, 10'd0, 16'h0000, 1'b0}, 1'b1, 2'd0, '0, '0},
        // Full diagonal: the tie makes rows the major axis, gradient of exactly one.
        '{'{OP_START, 10'd0, 10'd0, 10'd1023, 10'd1023, 16'hF800, 1'b0}, 1'b1, 2'd2,
          '{10'd0, 10'd0, 16'hF800, 1'b0, 16'hF800, 1'b0},
          '{10'd1023, 10'd1023, 16'hF800, 1'b0, 16'hF800, 1'b0}},
        '{'{OP_ADVANCE, 10'd5, 10'd6, 10'd7, 10'd8, 16'h1111, 1'b1}, 1'b0, 2'd0, '0, '0},
        '{'{OP_ADVANCE, 10'd0, 10'd0, 10'd0, 10'd0, 16'h0000, 1'b0}, 1'b0, 2'd0, '0, '0},
        // Anti-diagonal in bright mode, negative gradient of one.
        '{'{OP_START, 10'd1023, 10'd0, 10'd0, 10'd1023, 16'h07C0, 1'b1}, 1'b1, 2'd2,
          '{10'd1023, 10'd0, 16'h07C0, 1'b0, 16'h07C0, 1'b0},
          '{10'd0, 10'd1023, 16'h07C0, 1'b0, 16'h07C0, 1'b0}},
        '{'{OP_ADVANCE, 10'd0, 10'd0, 10'd0, 10'd0, 16'h0000, 1'b0}, 1'b0, 2'd0, '0, '0},
        '{'{OP_ADVANCE, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 16'hFFFF, 1'b1},
          1'b0, 2'd0, '0, '0},
        // Shallow line given right to left, so the endpoints are swapped.
        '{'{OP_START, 10'd13, 10'd14, 10'd3, 10'd10, 16'hFFFF, 1'b0}, 1'b0, 2'd0, '0, '0},
        '{'{OP_ADVANCE, 10'd0, 10'd0, 10'd0, 10'd0, 16'h0000, 1'b0}, 1'b0, 2'd0, '0, '0},
        '{'{OP_ADVANCE, 10'd0, 10'd0, 10'd0, 10'd0, 16'h0000, 1'b0}, 1'b0, 2'd0, '0, '0},
        '{'{OP_ADVANCE, 10'd0, 10'd0, 10'd0, 10'd0, 16'h0000, 1'b0}, 1'b0, 2'd0, '0, '0},
        // Short line: the second endpoint finishes it and an advance does nothing.
        '{'{OP_START, 10'd100, 10'd200, 10'd101, 10'd200, 16'h001F, 1'b0}, 1'b1, 2'd2,
          '{10'd100, 10'd200, 16'h001F, 1'b0, 16'h001F, 1'b0},
          '{10'd101, 10'd200, 16'h001F, 1'b0, 16'h001F, 1'b1}},
        '{'{OP_ADVANCE, 10'd0, 10'd0, 10'd0, 10'd0, 16'h0000, 1'b0}, 1'b1, 2'd0, '0, '0},
        // A single interior column, finished by its one advance.
        '{'{OP_START, 10'd5, 10'd5, 10'd7, 10'd6, 16'h8421, 1'b1}, 1'b0, 2'd0, '0, '0},
        '{'{OP_ADVANCE, 10'd0, 10'd0, 10'd0, 10'd0, 16'h0000, 1'b0}, 1'b0, 2'd0, '0, '0},
        '{'{OP_ADVANCE, 10'd0, 10'd0, 10'd0, 10'd0, 16'h0000, 1'b0}, 1'b1, 2'd0, '0, '0},
        // Steep line, bright blending, abandoned by the next start.
        '{'{OP_START, 10'd50, 10'd90, 10'd47, 10'd60, 16'h1234, 1'b1}, 1'b0, 2'd0, '0, '0},
        '{'{OP_ADVANCE, 10'd0, 10'd0, 10'd0, 10'd0, 16'h0000, 1'b0}, 1'b0, 2'd0, '0, '0},
        '{'{OP_ADVANCE, 10'd0, 10'd0, 10'd0, 10'd0, 16'h0000, 1'b0}, 1'b0, 2'd0, '0, '0},
        '{'{OP_START, 10'd600, 10'd300, 10'd300, 10'd301, 16'hFFDF, 1'b1}, 1'b0, 2'd0,
          '0, '0},
        '{'{OP_ADVANCE, 10'd0, 10'd0, 10'd0, 10'd0, 16'h0000, 1'b0}, 1'b0, 2'd0, '0, '0}
    };

    task automatic report(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTED) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            report($sformatf("pixel %0d: %s expected 0x%0h, got 0x%0h",
                             pixels_seen, name, want, got));
        end
    endtask

    // Scales each 5-bit component of the held colour by a coverage in Q.16, or
    // in bright mode adds the missing coverage as a whitening term and saturates.
    // Bit 5 of the colour never survives blending.
    function automatic logic [COLOR_BITS-1:0] shade(input int cov);
        int lsb [3];
        int v;
        logic [COLOR_BITS-1:0] c;
        lsb = '{R_LSB, G_LSB, B_LSB};
        c = '0;
        for (int k = 0; k < 3; k++) begin
            v = int'(ln_colour[lsb[k] +: COMP_BITS]);
            if (ln_bright) begin
                v = v + ((int'(COMP_MAX) * ((1 << FRAC_BITS) - cov)) >> FRAC_BITS);
                if (v > int'(COMP_MAX)) begin
                    v = int'(COMP_MAX);
                end
            end else begin
                v = (v * cov) >> FRAC_BITS;
            end
            c[lsb[k] +: COMP_BITS] = v[COMP_BITS-1:0];
        end
        return c;
    endfunction

    // Maps major and minor coordinates back to columns and rows.
    function automatic t_px place(input t_coord major, input t_coord minor,
                                  input logic [COLOR_BITS-1:0] colour,
                                  input logic cond, input logic done);
        t_px p;
        p.x      = ln_steep ? minor : major;
        p.y      = ln_steep ? major : minor;
        p.colour = colour;
        p.cond   = cond;
        p.cmp    = ln_colour;
        p.done   = done;
        return p;
    endfunction

    // Advances the predicted line state by one accepted request and returns the
    // number of pixels it causes, the pixels themselves in p0 and p1.
    function automatic int plot_request(input t_req r, output t_px p0, output t_px p1);
        t_coord adx, ady, a0, b0, a1, b1, tmp, span, dmag, base;
        logic neg, lastcol;
        logic [DIV_BITS-1:0] mag;
        logic [ACC_BITS-1:0] sext;
        logic [FRAC_BITS-1:0] f;
        p0 = '0;
        p1 = '0;
        sext = {{(ACC_BITS - SLOPE_BITS){ln_slope[SLOPE_BITS-1]}}, ln_slope};
        if (r.op == OP_START) begin
            adx = (r.x1 > r.x2) ? r.x1 - r.x2 : r.x2 - r.x1;
            ady = (r.y1 > r.y2) ? r.y1 - r.y2 : r.y2 - r.y1;
            ln_colour = r.colour;
            ln_bright = r.bright;
            // Equal spans fall to the row axis.
            ln_steep  = !(adx > ady);
            if (adx == 0 && ady == 0) begin
                ln_active = 1'b0;
                p0 = place(r.y1, r.x1, ln_colour, 1'b0, 1'b1);
                return 1;
            end
            if (!ln_steep) begin
                a0 = r.x1; b0 = r.y1; a1 = r.x2; b1 = r.y2;
            end else begin
                a0 = r.y1; b0 = r.x1; a1 = r.y2; b1 = r.x2;
            end
            if (a1 < a0) begin
                tmp = a0; a0 = a1; a1 = tmp;
                tmp = b0; b0 = b1; b1 = tmp;
            end
            span = a1 - a0;
            neg  = b1 < b0;
            dmag = neg ? b0 - b1 : b1 - b0;
            mag  = {dmag, {FRAC_BITS{1'b0}}} / span;
            ln_slope = neg ? -mag[SLOPE_BITS-1:0] : mag[SLOPE_BITS-1:0];
            sext = {{(ACC_BITS - SLOPE_BITS){ln_slope[SLOPE_BITS-1]}}, ln_slope};
            // The first interior column already sits one gradient step along.
            ln_accum     = {b0, {FRAC_BITS{1'b0}}} + sext;
            ln_major     = a0 + 1'b1;
            ln_major_end = a1;
            ln_active    = span >= 2;
            p0 = place(a0, b0, ln_colour, 1'b0, 1'b0);
            p1 = place(a1, b1, ln_colour, 1'b0, !ln_active);
            return 2;
        end
        if (!ln_active) begin
            return 0;
        end
        lastcol = ({1'b0, ln_major} + 11'd1) >= {1'b0, ln_major_end};
        f       = ln_accum[FRAC_BITS-1:0];
        base    = ln_accum[FRAC_BITS +: COORD_BITS];
        ln_accum = ln_accum + sext;
        ln_major = ln_major + 1'b1;
        if (lastcol) begin
            ln_active = 1'b0;
        end
        if (f == 0) begin
            // The line passes exactly through a pixel centre.
            p0 = place(ln_major - 1'b1, base, ln_colour, 1'b0, lastcol);
            return 1;
        end
        p0 = place(ln_major - 1'b1, base, shade((1 << FRAC_BITS) - int'(f)), 1'b1, 1'b0);
        p1 = place(ln_major - 1'b1, base + 1'b1, shade(int'(f)), 1'b1, lastcol);
        return 2;
    endfunction

    // Offers one request and, once it is taken, files what it must produce.
    task automatic offer(input t_req r, input logic typed, input logic [1:0] n_typed,
                         input t_px t0, input t_px t1, output int n);
        t_px p0, p1;
        @(negedge clk);
        line_if.valid       <= 1'b1;
        line_if.operation   <= r.op;
        line_if.start_x     <= r.x1;
        line_if.start_y     <= r.y1;
        line_if.end_x       <= r.x2;
        line_if.end_y       <= r.y2;
        line_if.line_color  <= r.colour;
        line_if.bright_mode <= r.bright;
        do @(posedge clk); while (line_if.ready !== 1'b1);
        n = plot_request(r, p0, p1);
        if (typed) begin
            n  = int'(n_typed);
            p0 = t0;
            p1 = t1;
        end
        if (n > 0) pending_pixels.push_back(p0);
        if (n > 1) pending_pixels.push_back(p1);
    endtask

    // Bursts of back-to-back requests separated by short gaps. While the
    // receiver is held off the sender keeps pushing so that the block backs up.
    task automatic pace();
        int gap;
        if (burst_left > 0 || hold_on) begin
            if (burst_left > 0) burst_left--;
            return;
        end
        gap = $urandom_range(1, 8);
        burst_left = ($urandom_range(0, 9) == 0) ? 120 : $urandom_range(1, 20);
        repeat (gap) begin
            @(negedge clk);
            line_if.valid <= 1'b0;
        end
    endtask

    function automatic t_req random_request(input t_op op);
        t_req r;
        r.op     = op;
        r.x1     = t_coord'($urandom_range(0, (1 << COORD_BITS) - 1));
        r.y1     = t_coord'($urandom_range(0, (1 << COORD_BITS) - 1));
        r.x2     = t_coord'($urandom_range(0, (1 << COORD_BITS) - 1));
        r.y2     = t_coord'($urandom_range(0, (1 << COORD_BITS) - 1));
        r.colour = COLOR_BITS'($urandom_range(0, (1 << COLOR_BITS) - 1));
        r.bright = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic t_coord clamp_coord(input int v);
        if (v < 0) return '0;
        if (v > (1 << COORD_BITS) - 1) return '1;
        return t_coord'(v);
    endfunction

    // Receiver: changes its stall pattern after each stretch of random length and,
    // when the sender asks, refuses pixels for a long stretch counted here.
    initial begin
        t_rx_mode mode;
        int len;
        int tick;
        pix_if.ready = 1'b0;
        tick = 0;
        forever begin
            mode = t_rx_mode'($urandom_range(0, 3));
            len  = $urandom_range(8, 60);
            repeat (len) begin
                @(negedge clk);
                tick++;
                if (hold_req) begin
                    pix_if.ready <= 1'b0;
                    hold_on  = 1'b1;
                    hold_req = 1'b0;
                    repeat (HOLD_CYCLES) @(negedge clk);
                    hold_on = 1'b0;
                end else begin
                    case (mode)
                        RX_FREE:   pix_if.ready <= 1'b1;
                        RX_COIN:   pix_if.ready <= 1'($urandom_range(0, 1));
                        RX_SPARSE: pix_if.ready <= ($urandom_range(0, 3) == 0);
                        default:   pix_if.ready <= (tick % 3 != 0);
                    endcase
                end
            end
        end
    end

    // Pixel checker: every pixel taken is compared with the oldest one filed.
    always @(posedge clk) begin : pixel_check
        t_px want;
        if (rst_n === 1'b1 && pix_if.valid === 1'b1 && pix_if.ready === 1'b1) begin
            pixels_seen++;
            if (pending_pixels.size() == 0) begin
                report($sformatf("pixel %0d: (%0d,%0d) arrived with none pending",
                                 pixels_seen, pix_if.pixel_x, pix_if.pixel_y));
            end else begin
                want = pending_pixels.pop_front();
                check_field("pixel_x", want.x, pix_if.pixel_x);
                check_field("pixel_y", want.y, pix_if.pixel_y);
                check_field("pixel_color", want.colour, pix_if.pixel_color);
                check_field("only_if_differs", want.cond, pix_if.only_if_differs);
                check_field("compare_color", want.cmp, pix_if.compare_color);
                check_field("line_done", want.done, pix_if.line_done);
            end
        end
    end

    initial begin
        #TIMEOUT_NS;
        $display("antialiased_line_rasterizer_tb failed");
        $finish;
    end

    initial begin
        t_req r;
        int n, counted, lines_sent, sz, reach, n_adv, adx, ady;
        line_if.valid       = 1'b0;
        line_if.operation   = OP_START;
        line_if.start_x     = '0;
        line_if.start_y     = '0;
        line_if.end_x       = '0;
        line_if.end_y       = '0;
        line_if.line_color  = '0;
        line_if.bright_mode = 1'b0;
        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            pace();
            offer(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].n_typed,
                  directed_rows[i].p0, directed_rows[i].p1, n);
        end

        // Random part: mostly whole lines with random content, some abandoned
        // early, some overrun by stray advances, and a little pure noise.
        counted    = 0;
        lines_sent = 0;
        while (counted < RANDOM_ITEMS) begin
            if ($urandom_range(0, 99) < 8) begin
                r = random_request(OP_ADVANCE);
                pace();
                offer(r, 1'b0, 2'd0, '0, '0, n);
                if (n > 0) counted++;
                continue;
            end
            if (lines_sent == HOLD_LINE) begin
                hold_req = 1'b1;
            end
            if (lines_sent == DRAIN_LINE) begin
                // Let the block run completely dry before the next line.
                @(negedge clk);
                line_if.valid <= 1'b0;
                while (pending_pixels.size() != 0) @(posedge clk);
            end
            r  = random_request(OP_START);
            sz = $urandom_range(0, 99);
            if (sz < 5) begin
                r.x2 = r.x1;
                r.y2 = r.y1;
            end else if (sz < 95) begin
                // Most lines are short; a few reach further. Long lines come
                // only from the fully random endpoints below.
                reach = (sz < 78) ? 12 : 80;
                r.x2 = clamp_coord(int'(r.x1) + int'($urandom_range(0, 2 * reach)) - reach);
                r.y2 = clamp_coord(int'(r.y1) + int'($urandom_range(0, 2 * reach)) - reach);
            end
            adx   = (r.x1 > r.x2) ? r.x1 - r.x2 : r.x2 - r.x1;
            ady   = (r.y1 > r.y2) ? r.y1 - r.y2 : r.y2 - r.y1;
            n_adv = ((adx > ady) ? adx : ady) - 1;
            if (n_adv < 0) n_adv = 0;
            if (sz >= 95) begin
                n_adv = (n_adv < 30) ? n_adv : $urandom_range(0, 30);
            end else if ($urandom_range(0, 99) < 12) begin
                n_adv = $urandom_range(0, n_adv);
            end
            if ($urandom_range(0, 99) < 10) begin
                n_adv += $urandom_range(1, 2);
            end
            pace();
            offer(r, 1'b0, 2'd0, '0, '0, n);
            counted++;
            lines_sent++;
            repeat (n_adv) begin
                r = random_request(OP_ADVANCE);
                pace();
                offer(r, 1'b0, 2'd0, '0, '0, n);
                if (n > 0) counted++;
            end
        end

        @(negedge clk);
        line_if.valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge clk);
        // Any pixel still to come would be one too many.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("antialiased_line_rasterizer_tb passed");
        end else begin
            $display("antialiased_line_rasterizer_tb failed");
        end
        $finish;
    end

endmodule

// File: antialiased_line_rasterizer.f
rtl/core/alr_pkg.sv
rtl/core/alr_if.sv
rtl/core/alr_front.sv
rtl/core/alr_queue.sv
rtl/core/alr_back.sv
rtl/core/antialiased_line_rasterizer.sv
rtl/core/alr_checker.sv
tb/sv/antialiased_line_rasterizer_tb.sv
